/* hw/rtl/kcts_pkg.sv */
`timescale 1ns / 1ps

package kcts_pkg;

  // Table geometry: one memory row holds every way of a bin; bin count is a power of two.
  localparam int BINS  = 4096;
  localparam int WAYS  = 4;
  localparam int BIN_W = $clog2(BINS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam int POS_W = 32;

  localparam logic [5:0] WS_RESET = 6'd21;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BASE = 2'd1;
  localparam logic [1:0] ST_BIN_FULL = 2'd2;

  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_N = 8'h4E;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [CNT_W-1:0] count;
    logic             free;
    logic [WAY_W-1:0] free_way;
  } probe_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [POS_W-1:0] pos;
  } roll_res_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [KEY_W-1:0] key);
    bin_of = key[BIN_W-1:0];
  endfunction

endpackage

/* hw/rtl/kcts_ram.sv */
`timescale 1ns / 1ps

module kcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/kcts_probe.sv */
`timescale 1ns / 1ps

module kcts_probe (
  input  logic                        clk,
  input  kcts_pkg::row_t              row,
  input  logic [kcts_pkg::KEY_W-1:0]  key,
  output kcts_pkg::probe_t            res
);

  kcts_pkg::probe_t probe_nxt;
  kcts_pkg::probe_t probe_r;

  // Lowest matching way and lowest free way win.
  always_comb begin
    probe_nxt = '0;
    for (int w = kcts_pkg::WAYS - 1; w >= 0; w--) begin
      if (row[w].used && (row[w].key == key)) begin
        probe_nxt.hit     = 1'b1;
        probe_nxt.hit_way = kcts_pkg::WAY_W'(w);
        probe_nxt.count   = row[w].count;
      end
      if (!row[w].used) begin
        probe_nxt.free     = 1'b1;
        probe_nxt.free_way = kcts_pkg::WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
  end

  assign res = probe_r;

endmodule

/* hw/rtl/kcts_roll.sv */
`timescale 1ns / 1ps

module kcts_roll (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        seq_start,
  input  logic [7:0]                  base,
  input  logic [5:0]                  kmer_len,
  output kcts_pkg::roll_res_t         res,
  output logic [kcts_pkg::KEY_W-1:0]  fwd_code,
  output logic [kcts_pkg::KEY_W-1:0]  rev_code
);

  logic [kcts_pkg::KEY_W-1:0] fwd_r, rev_r;
  logic [5:0]                 fill_r;
  logic [kcts_pkg::POS_W-1:0] idx_r;

  logic [kcts_pkg::KEY_W-1:0] fwd_nxt, rev_nxt, mask, top, fwd_base, rev_base;
  logic [5:0]                 fill_nxt, fill_base, k;
  logic [kcts_pkg::POS_W-1:0] idx_nxt, idx_base;
  logic [kcts_pkg::POS_W-1:0] sum;
  logic [1:0]                 code;
  logic                       good, bad, full;

  always_comb begin
    if (kmer_len == 6'd0) begin
      k = 6'd1;
    end else if (kmer_len > 6'd32) begin
      k = 6'd32;
    end else begin
      k = kmer_len;
    end

    code = 2'd0;
    good = 1'b1;
    bad  = 1'b0;
    case (base)
      kcts_pkg::CH_T: code = 2'd0;
      kcts_pkg::CH_C: code = 2'd1;
      kcts_pkg::CH_G: code = 2'd2;
      kcts_pkg::CH_A: code = 2'd3;
      kcts_pkg::CH_N: good = 1'b0;
      default: begin
        good = 1'b0;
        bad  = 1'b1;
      end
    endcase

    fwd_base  = seq_start ? '0 : fwd_r;
    rev_base  = seq_start ? '0 : rev_r;
    fill_base = seq_start ? '0 : fill_r;
    idx_base  = seq_start ? '0 : idx_r;

    // Mask covers k bases; the complement of the new base enters at base k-1.
    for (int i = 0; i < 32; i++) begin
      mask[2*i +: 2] = (6'(i) < k) ? 2'b11 : 2'b00;
      top[2*i +: 2]  = (6'(i) == (k - 6'd1)) ? ~code : 2'b00;
    end

    full     = 1'b0;
    fill_nxt = fill_base;
    if (!good) begin
      fwd_nxt  = '0;
      rev_nxt  = '0;
      fill_nxt = '0;
    end else begin
      fwd_nxt = {fwd_base[kcts_pkg::KEY_W-3:0], code} & mask;
      rev_nxt = (((rev_base & mask) >> 2) | top) & mask;
      if (fill_base < k) begin
        fill_nxt = fill_base + 6'd1;
      end
      if (fill_nxt >= k) begin
        fill_nxt = k;
        full     = 1'b1;
      end
    end

    idx_nxt = (idx_base == '1) ? idx_base : idx_base + 1'b1;

    // index plus one wraps to zero at the saturated index, giving position zero
    sum       = idx_base + 1'b1;
    res.valid = full;
    res.bad   = bad;
    res.pos   = '0;
    if (full && (sum >= {26'd0, k})) begin
      res.pos = sum - {26'd0, k};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      fill_r <= '0;
      idx_r  <= '0;
    end else if (step) begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign fwd_code = fwd_r;
  assign rev_code = rev_r;

endmodule

/* hw/rtl/kmer_count_table_scanner.sv */
`timescale 1ns / 1ps
// Sequence: an insert steps through read, compare and write states, then done; a scan base
// that completes a window reads the fwd then the rev bin, one read-compare pass per probe,
// then done; any other scan base goes straight to done. out_tvalid rises as done hands over.
// Flow: one item at a time; a new item is taken while the previous result still waits on
// the output. Reset: synchronous active-low; afterwards a clearing pass writes all 4096 bins
// and no item is accepted meanwhile; configuration writes are taken throughout.
module kmer_count_table_scanner (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata,     // k-mer length in bases
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,      // key[63:0], amount[95:64], base[103:96], seq_start[104]
  input  logic [0:0]   in_tuser,      // operation[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,     // position[31:0], fwd_count[63:32], rev_count[95:64]
  output logic [2:0]   out_tuser      // window_valid[0], status[2:1]
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_SCAN,
    S_FWD_RD,
    S_REV_RD,
    S_REV_CMP,
    S_REV_TAKE,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [kcts_pkg::BIN_W-1:0]    clr_r;
  logic [5:0]                    kmer_len_r;

  logic [kcts_pkg::KEY_W-1:0]    key_r;
  logic [kcts_pkg::CNT_W-1:0]    amt_r;
  logic [7:0]                    base_r;
  logic                          seq_r;

  logic                          wv_r;
  logic [kcts_pkg::POS_W-1:0]    pos_r;
  logic [kcts_pkg::CNT_W-1:0]    fc_r, rc_r;
  logic [1:0]                    st_r;

  logic                          out_valid_r;
  logic                          out_wv_r;
  logic [kcts_pkg::POS_W-1:0]    out_pos_r;
  logic [kcts_pkg::CNT_W-1:0]    out_fc_r, out_rc_r;
  logic [1:0]                    out_st_r;

  logic                          ram_we, ram_re;
  logic [kcts_pkg::BIN_W-1:0]    ram_waddr, ram_raddr;
  logic [$bits(kcts_pkg::row_t)-1:0] ram_wdata, ram_rdata;
  kcts_pkg::row_t                ram_row, row_upd;

  kcts_pkg::probe_t              probe;
  logic [kcts_pkg::KEY_W-1:0]    probe_key;

  kcts_pkg::roll_res_t           roll;
  logic [kcts_pkg::KEY_W-1:0]    fwd_code, rev_code;

  logic                          in_fire, out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  kcts_ram #(
    .WIDTH($bits(kcts_pkg::row_t)),
    .DEPTH(kcts_pkg::BINS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_row = ram_rdata;

  kcts_probe u_probe (
    .clk(clk),
    .row(ram_row),
    .key(probe_key),
    .res(probe)
  );

  kcts_roll u_roll (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (state_r == S_SCAN),
    .seq_start  (seq_r),
    .base       (base_r),
    .kmer_len   (kmer_len_r),
    .res        (roll),
    .fwd_code   (fwd_code),
    .rev_code   (rev_code)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = kcts_pkg::bin_of(key_r);
    ram_raddr = kcts_pkg::bin_of(key_r);
    probe_key = key_r;
    row_upd   = ram_row;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_INS_RD: ram_re = 1'b1;
      S_INS_WR: begin
        if (probe.hit) begin
          row_upd[probe.hit_way].count = probe.count + amt_r;
          ram_we = 1'b1;
        end else if (probe.free) begin
          row_upd[probe.free_way].used  = 1'b1;
          row_upd[probe.free_way].key   = key_r;
          row_upd[probe.free_way].count = amt_r;
          ram_we = 1'b1;
        end
      end
      S_FWD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = kcts_pkg::bin_of(fwd_code);
      end
      S_REV_RD: begin
        // fwd row is on the read port now; fetch the rev row behind it
        ram_re    = 1'b1;
        ram_raddr = kcts_pkg::bin_of(rev_code);
        probe_key = fwd_code;
      end
      S_REV_CMP: probe_key = rev_code;
      default: ;
    endcase
    ram_wdata = (state_r == S_CLEAR) ? '0 : row_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      kmer_len_r    <= kcts_pkg::WS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        kmer_len_r <= cfg_wdata;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == kcts_pkg::BIN_W'(kcts_pkg::BINS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            key_r  <= in_tdata[63:0];
            amt_r  <= in_tdata[95:64];
            base_r <= in_tdata[103:96];
            seq_r  <= in_tdata[104];
            wv_r   <= 1'b0;
            pos_r  <= '0;
            fc_r   <= '0;
            rc_r   <= '0;
            st_r   <= kcts_pkg::ST_OK;
            state_r <= (in_tuser[0] == kcts_pkg::OP_INSERT) ? S_INS_RD : S_SCAN;
          end
        end
        S_INS_RD:  state_r <= S_INS_CMP;
        S_INS_CMP: state_r <= S_INS_WR;
        S_INS_WR: begin
          if (!probe.hit && !probe.free) begin
            st_r <= kcts_pkg::ST_BIN_FULL;
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          wv_r    <= roll.valid;
          pos_r   <= roll.pos;
          st_r    <= roll.bad ? kcts_pkg::ST_BAD_BASE : kcts_pkg::ST_OK;
          state_r <= roll.valid ? S_FWD_RD : S_DONE;
        end
        S_FWD_RD:  state_r <= S_REV_RD;
        S_REV_RD:  state_r <= S_REV_CMP;
        S_REV_CMP: begin
          fc_r    <= probe.hit ? probe.count : '0;
          state_r <= S_REV_TAKE;
        end
        S_REV_TAKE: begin
          rc_r    <= probe.hit ? probe.count : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_wv_r    <= wv_r;
            out_pos_r   <= pos_r;
            out_fc_r    <= fc_r;
            out_rc_r    <= rc_r;
            out_st_r    <= st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rc_r, out_fc_r, out_pos_r};
  assign out_tuser  = {out_st_r, out_wv_r};

endmodule
